@@ rtl/core/nhm_pkg.sv @@
// Shared types and constants for the nearest histogram match unit.
package nhm_pkg;

  localparam int DIST_W    = 48;
  localparam int SLOT_W    = 6;
  localparam int BIN_IDX_W = 9;
  localparam int BIN_VAL_W = 16;
  localparam int COUNT_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] LIMIT_RESET = DIST_W'(64'd1000 << 16);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_COUNT    = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [SLOT_W-1:0]    model_slot;
    logic [BIN_IDX_W-1:0] bin_index;
    logic [BIN_VAL_W-1:0] bin_value;
    logic                 last_bin;
  } in_req_t;

  typedef struct packed {
    logic              match_found;
    logic [SLOT_W-1:0] match_slot;
    logic [DIST_W-1:0] best_distance;
  } out_rsp_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } bin_tag_t;

endpackage

@@ rtl/core/nhm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module nhm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 308
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/nhm_dist_unit.sv @@
// Shared absolute-difference, square and saturating accumulate pipeline.
module nhm_dist_unit import nhm_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bin_tag_t              tag,
  input  logic [VALUE_BITS-1:0] model_value,
  input  logic [VALUE_BITS-1:0] query_value,
  output logic                  sum_valid,
  output logic [DIST_W-1:0]     sum,
  output logic                  busy
);

  localparam int SQ_W  = 2 * VALUE_BITS;
  localparam int ADD_W = (SQ_W > DIST_W ? SQ_W : DIST_W) + 1;

  bin_tag_t              tag_d;
  bin_tag_t              tag_sq;
  logic [VALUE_BITS-1:0] diff;
  logic [SQ_W-1:0]       sq;
  logic [ADD_W-1:0]      total;

  always_comb begin
    if (model_value >= query_value) begin
      diff = model_value - query_value;
    end else begin
      diff = query_value - model_value;
    end
  end

  assign total = (tag_sq.first ? '0 : ADD_W'(sum)) + ADD_W'(sq);
  assign busy  = tag_d.valid | tag_sq.valid | sum_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d     <= '0;
      tag_sq    <= '0;
      sum_valid <= 1'b0;
    end else begin
      tag_d     <= tag;
      tag_sq    <= tag_d;
      sum_valid <= tag_sq.valid & tag_sq.last;
    end
  end

  always_ff @(posedge clk) begin
    sq <= SQ_W'(diff) * SQ_W'(diff);
    if (tag_sq.valid) begin
      if (total >= ADD_W'(DIST_MAX)) begin
        sum <= DIST_MAX;
      end else begin
        sum <= total[DIST_W-1:0];
      end
    end
  end

endmodule

@@ rtl/core/nearest_histogram_match_unit.sv @@
// Top level of the nearest histogram match unit: stores, sequencer and result register.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+-------------------------------
//   in      | in_valid / in_ready    | in_data  (in_req_t)
//   out     | out_valid / out_ready  | out_data (out_rsp_t)
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Load and query requests are taken only while idle; a query with last_bin set then
// holds in_ready low while min(model_count, MAX_MODELS) models are scanned and until
// the result is registered, or only until then when model_count is zero.
// The scan is paced by the single difference-square-accumulate unit and the
// one read port of the model store, which deliver one bin per cycle.
// A pending result in the output register stalls only the end of the next search.
// Reset is synchronous; the stores are not cleared and need no clearing pass.
module nearest_histogram_match_unit import nhm_pkg::*; #(
  parameter int MAX_MODELS = 64,
  parameter int BINS       = 308,
  parameter int VALUE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_rsp_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data
);

  localparam int BIN_AW   = BINS > 1 ? $clog2(BINS) : 1;
  localparam int SLOT_AW  = MAX_MODELS > 1 ? $clog2(MAX_MODELS) : 1;
  localparam int MODEL_AW = MAX_MODELS * BINS > 1 ? $clog2(MAX_MODELS * BINS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t                  state;
  logic [DIST_W-1:0]       distance_limit;
  logic [COUNT_W-1:0]      model_count;
  logic [BIN_AW-1:0]       bin_cnt;
  logic [SLOT_AW-1:0]      issue_slot;
  logic [SLOT_AW-1:0]      last_slot;
  logic [SLOT_AW-1:0]      cmp_slot;
  logic [MODEL_AW-1:0]     model_addr;
  logic [DIST_W-1:0]       best;
  logic [SLOT_AW-1:0]      best_slot;
  logic                    found;

  logic                    in_fire;
  logic                    slot_ok;
  logic                    bin_ok;
  logic                    model_we;
  logic                    query_we;
  logic [MODEL_AW-1:0]     load_addr;
  logic [VALUE_BITS-1:0]   wr_value;
  logic [VALUE_BITS-1:0]   model_value;
  logic [VALUE_BITS-1:0]   query_value;
  logic [SLOT_AW-1:0]      last_slot_start;
  logic                    bin_wrap;
  bin_tag_t                tag;
  logic                    sum_valid;
  logic [DIST_W-1:0]       sum;
  logic                    unit_busy;
  logic                    out_free;
  logic                    finish;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid & in_ready;
  assign slot_ok   = 32'(in_data.model_slot) < MAX_MODELS;
  assign bin_ok    = 32'(in_data.bin_index) < BINS;
  assign model_we  = in_fire & (in_data.cmd == CMD_LOAD) & slot_ok & bin_ok;
  assign query_we  = in_fire & (in_data.cmd == CMD_QUERY) & bin_ok;
  assign load_addr = MODEL_AW'(32'(in_data.model_slot) * 32'(BINS) + 32'(in_data.bin_index));
  assign wr_value  = VALUE_BITS'(in_data.bin_value);
  assign bin_wrap  = (bin_cnt == BIN_AW'(BINS - 1));
  assign out_free  = !out_valid | out_ready;
  assign finish    = (state == ST_DRAIN) & !unit_busy & out_free;

  always_comb begin
    if (32'(model_count) >= MAX_MODELS) begin
      last_slot_start = SLOT_AW'(MAX_MODELS - 1);
    end else begin
      last_slot_start = SLOT_AW'(model_count - COUNT_W'(1));
    end
  end

  always_comb begin
    tag.valid = (state == ST_SCAN);
    tag.first = (bin_cnt == '0);
    tag.last  = bin_wrap;
  end

  nhm_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_MODELS * BINS)
  ) u_model_store (
    .clk  (clk),
    .we   (model_we),
    .waddr(load_addr),
    .wdata(wr_value),
    .raddr(model_addr),
    .rdata(model_value)
  );

  nhm_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(BINS)
  ) u_query_buffer (
    .clk  (clk),
    .we   (query_we),
    .waddr(BIN_AW'(in_data.bin_index)),
    .wdata(wr_value),
    .raddr(bin_cnt),
    .rdata(query_value)
  );

  nhm_dist_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dist_unit (
    .clk        (clk),
    .rst        (rst),
    .tag        (tag),
    .model_value(model_value),
    .query_value(query_value),
    .sum_valid  (sum_valid),
    .sum        (sum),
    .busy       (unit_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit <= LIMIT_RESET;
      model_count    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DISTANCE_LIMIT: distance_limit <= cfg_data;
        CFG_MODEL_COUNT:    model_count    <= cfg_data[COUNT_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      out_data   <= '0;
      bin_cnt    <= '0;
      issue_slot <= '0;
      last_slot  <= '0;
      cmp_slot   <= '0;
      model_addr <= '0;
      best       <= '0;
      best_slot  <= '0;
      found      <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (sum_valid) begin
        cmp_slot <= cmp_slot + SLOT_AW'(1);
        if (sum < best) begin
          best      <= sum;
          best_slot <= cmp_slot;
          found     <= 1'b1;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && in_data.cmd == CMD_QUERY && in_data.last_bin) begin
            bin_cnt    <= '0;
            issue_slot <= '0;
            cmp_slot   <= '0;
            model_addr <= '0;
            last_slot  <= last_slot_start;
            best       <= distance_limit;
            best_slot  <= '0;
            found      <= 1'b0;
            state      <= (model_count == '0) ? ST_DRAIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          model_addr <= model_addr + MODEL_AW'(1);
          if (bin_wrap) begin
            bin_cnt    <= '0;
            issue_slot <= issue_slot + SLOT_AW'(1);
            if (issue_slot == last_slot) begin
              state <= ST_DRAIN;
            end
          end else begin
            bin_cnt <= bin_cnt + BIN_AW'(1);
          end
        end
        ST_DRAIN: begin
          if (finish) begin
            out_valid              <= 1'b1;
            out_data.match_found   <= found;
            out_data.match_slot    <= SLOT_W'(best_slot);
            out_data.best_distance <= best;
            state                  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_sum_only_in_search: assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("distance sum completed outside a search");

  a_cmp_slot_bound: assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> (cmp_slot <= last_slot))
    else $error("more model distances than models searched");

  a_found_below_limit: assert property (@(posedge clk) disable iff (rst)
    finish |-> (!found || best < distance_limit))
    else $error("match reported at or above the distance limit");

  a_result_from_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DRAIN)
    else $error("result raised outside the end of a search");

endmodule
